/* sv/cts_pkg.sv */
// Shared types and codes for the conveyor transport sequencer.
// Holds the transaction payload structs, configuration struct and encodings.
// No dependencies; compiled before every other file.
package cts_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] REG_STARTUP_SCREEN = 3'd0;
	localparam logic [2:0] REG_START_DELAY    = 3'd1;
	localparam logic [2:0] REG_TARGET_WAIT    = 3'd2;
	localparam logic [2:0] REG_TRANSPORT_TO   = 3'd3;
	localparam logic [2:0] REG_MODE_SHOW      = 3'd4;

	localparam logic [15:0] STARTUP_SCREEN_RST = 16'd2000;
	localparam logic [15:0] START_DELAY_RST    = 16'd2000;
	localparam logic [15:0] TARGET_WAIT_RST    = 16'd5000;
	localparam logic [19:0] TRANSPORT_TO_RST   = 20'd30000;
	localparam logic [15:0] MODE_SHOW_RST      = 16'd1000;

	localparam logic [1:0] MODE_LEFT  = 2'd0;
	localparam logic [1:0] MODE_RIGHT = 2'd1;
	localparam logic [1:0] MODE_AUTO  = 2'd2;
	localparam logic [1:0] MODE_ALIAS = 2'd3;

	localparam logic [1:0] DIR_STOP  = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_SPEED = 2'd1;
	localparam logic [1:0] CMD_BRAKE = 2'd2;
	localparam logic [1:0] CMD_ESTOP = 2'd3;

	localparam logic [3:0] SCR_NONE      = 4'd0;
	localparam logic [3:0] SCR_STARTUP   = 4'd1;
	localparam logic [3:0] SCR_RELEASE   = 4'd2;
	localparam logic [3:0] SCR_AWAIT     = 4'd3;
	localparam logic [3:0] SCR_FAULT     = 4'd4;
	localparam logic [3:0] SCR_TARGET    = 4'd5;
	localparam logic [3:0] SCR_MODE_HINT = 4'd6;
	localparam logic [3:0] SCR_MODE_SHOW = 4'd7;
	localparam logic [3:0] SCR_OCCUPIED  = 4'd8;

	typedef struct packed {
		logic [15:0] startup_screen_ms;
		logic [15:0] start_delay_ms;
		logic [15:0] target_wait_ms;
		logic [19:0] transport_timeout_ms;
		logic [15:0] mode_show_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        left_barrier_active;
		logic        right_barrier_active;
		logic        left_barrier_rise;
		logic        left_barrier_fall;
		logic        right_barrier_rise;
		logic        right_barrier_fall;
		logic        button_rise;
		logic [1:0]  switch_mode;
		logic        switch_changed;
		logic        motor_standstill;
		logic [15:0] target_speed;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  seq_state;
		logic [1:0]  motor_cmd;
		logic [1:0]  drive_dir;
		logic [15:0] speed_cmd;
		logic [1:0]  active_mode;
		logic [3:0]  screen_event;
		logic        fault_timeout;
	} out_item_t;

endpackage

/* sv/cts_if.sv */
// Valid/ready channel interfaces for tick inputs and sequencer results.
// Depends on cts_pkg for nothing but shares its field widths.
interface cts_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        left_barrier_active;
	logic        right_barrier_active;
	logic        left_barrier_rise;
	logic        left_barrier_fall;
	logic        right_barrier_rise;
	logic        right_barrier_fall;
	logic        button_rise;
	logic [1:0]  switch_mode;
	logic        switch_changed;
	logic        motor_standstill;
	logic [15:0] target_speed;

	modport source (
		output valid, now_ms, left_barrier_active, right_barrier_active,
			left_barrier_rise, left_barrier_fall, right_barrier_rise,
			right_barrier_fall, button_rise, switch_mode, switch_changed,
			motor_standstill, target_speed,
		input ready
	);
	modport sink (
		input valid, now_ms, left_barrier_active, right_barrier_active,
			left_barrier_rise, left_barrier_fall, right_barrier_rise,
			right_barrier_fall, button_rise, switch_mode, switch_changed,
			motor_standstill, target_speed,
		output ready
	);
endinterface

interface cts_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  seq_state;
	logic [1:0]  motor_cmd;
	logic [1:0]  drive_dir;
	logic [15:0] speed_cmd;
	logic [1:0]  active_mode;
	logic [3:0]  screen_event;
	logic        fault_timeout;

	modport source (
		output valid, seq_state, motor_cmd, drive_dir, speed_cmd, active_mode,
			screen_event, fault_timeout,
		input ready
	);
	modport sink (
		input valid, seq_state, motor_cmd, drive_dir, speed_cmd, active_mode,
			screen_event, fault_timeout,
		output ready
	);
endinterface

/* sv/cts_cfg.sv */
// APB-style configuration register bank for the sequencer timing values.
// Depends on cts_pkg for the register indexes, reset values and cfg_t.
module cts_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cts_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cts_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cts_pkg::CFG_DATA_W-1:0] prdata,
	output logic                         pready,
	output cts_pkg::cfg_t                cfg
);
	import cts_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_screen_ms    <= STARTUP_SCREEN_RST;
			cfg_q.start_delay_ms       <= START_DELAY_RST;
			cfg_q.target_wait_ms       <= TARGET_WAIT_RST;
			cfg_q.transport_timeout_ms <= TRANSPORT_TO_RST;
			cfg_q.mode_show_ms         <= MODE_SHOW_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STARTUP_SCREEN: cfg_q.startup_screen_ms    <= pwdata[15:0];
				REG_START_DELAY:    cfg_q.start_delay_ms       <= pwdata[15:0];
				REG_TARGET_WAIT:    cfg_q.target_wait_ms       <= pwdata[15:0];
				REG_TRANSPORT_TO:   cfg_q.transport_timeout_ms <= pwdata[19:0];
				REG_MODE_SHOW:      cfg_q.mode_show_ms         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STARTUP_SCREEN: prdata = {16'd0, cfg_q.startup_screen_ms};
			REG_START_DELAY:    prdata = {16'd0, cfg_q.start_delay_ms};
			REG_TARGET_WAIT:    prdata = {16'd0, cfg_q.target_wait_ms};
			REG_TRANSPORT_TO:   prdata = {12'd0, cfg_q.transport_timeout_ms};
			REG_MODE_SHOW:      prdata = {16'd0, cfg_q.mode_show_ms};
			default:            prdata = '0;
		endcase
	end
endmodule

/* sv/cts_ctrl.sv */
// Sequencer state registers and the per-tick next-state and result logic.
// Depends on cts_pkg for the item structs, configuration struct and codes.
module cts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  cts_pkg::in_item_t  item,
	input  cts_pkg::cfg_t      cfg,
	output cts_pkg::out_item_t res
);
	import cts_pkg::*;

	typedef enum logic [3:0] {
		S_STARTUP  = 4'd0,
		S_RELEASE  = 4'd1,
		S_AWAIT    = 4'd2,
		S_DELAY    = 4'd3,
		S_RUN      = 4'd4,
		S_BRAKING  = 4'd5,
		S_TARGET   = 4'd6,
		S_STOPPED  = 4'd7,
		S_FAULT    = 4'd8,
		S_MODECHG  = 4'd9,
		S_MODESHOW = 4'd10
	} state_t;

	typedef struct packed {
		state_t      st;
		logic [31:0] ent;
		logic [1:0]  cmd;
		logic [3:0]  scr;
	} tick_t;

	function automatic tick_t issue(tick_t t, logic [1:0] c);
		tick_t r;
		r = t;
		if (t.cmd != CMD_ESTOP) begin
			r.cmd = c;
		end
		return r;
	endfunction

	function automatic tick_t enter(tick_t t, state_t s, logic [31:0] now);
		tick_t r;
		r     = t;
		r.st  = s;
		r.ent = now;
		unique case (s)
			S_STARTUP:  r.scr = SCR_STARTUP;
			S_RELEASE:  r.scr = SCR_RELEASE;
			S_AWAIT:    r.scr = SCR_AWAIT;
			S_FAULT: begin
				r     = issue(r, CMD_ESTOP);
				r.scr = SCR_FAULT;
			end
			S_TARGET: begin
				r     = issue(r, CMD_BRAKE);
				r.scr = SCR_TARGET;
			end
			S_MODECHG: begin
				r     = issue(r, CMD_BRAKE);
				r.scr = SCR_MODE_HINT;
			end
			S_STOPPED:  r = issue(r, CMD_BRAKE);
			S_BRAKING:  r = issue(r, CMD_BRAKE);
			S_MODESHOW: r.scr = SCR_MODE_SHOW;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic elapsed(logic [31:0] now, logic [31:0] ent, logic [19:0] limit);
		logic [31:0] diff;
		diff = now - ent;
		return diff >= {12'd0, limit};
	endfunction

	state_t      state_q;
	logic [1:0]  mode_q;
	logic [1:0]  dir_q;
	logic [31:0] entry_q;
	logic        fault_q;

	tick_t       t;
	logic [1:0]  md;
	logic [1:0]  dr;
	logic        flt;
	logic [1:0]  sw;
	logic [31:0] now;
	logic        l_act;
	logic        r_act;
	logic        button;

	always_comb begin
		now    = item.now_ms;
		l_act  = item.left_barrier_active;
		r_act  = item.right_barrier_active;
		button = item.button_rise;
		sw     = (item.switch_mode == MODE_ALIAS) ? MODE_AUTO : item.switch_mode;
		t.st   = state_q;
		t.ent  = entry_q;
		t.cmd  = CMD_NONE;
		t.scr  = SCR_NONE;
		md     = mode_q;
		dr     = dir_q;
		flt    = fault_q;

		if (state_q != S_STARTUP && state_q != S_RELEASE && state_q != S_FAULT &&
			item.switch_changed && sw != mode_q) begin
			t = enter(t, S_MODECHG, now);
		end

		unique case (t.st)
			S_STARTUP: begin
				if (elapsed(now, t.ent, {4'd0, cfg.startup_screen_ms})) begin
					t = enter(t, S_RELEASE, now);
				end
			end
			S_RELEASE: begin
				if (button) begin
					if (!l_act && !r_act) begin
						md = sw;
						t  = enter(t, S_AWAIT, now);
					end else begin
						t.scr = SCR_OCCUPIED;
					end
				end
			end
			S_AWAIT: begin
				if (md == MODE_LEFT) begin
					if (item.right_barrier_rise) begin
						dr = DIR_LEFT;
						t  = enter(t, S_DELAY, now);
					end
				end else if (md == MODE_RIGHT) begin
					if (item.left_barrier_rise) begin
						dr = DIR_RIGHT;
						t  = enter(t, S_DELAY, now);
					end
				end else begin
					if (item.left_barrier_rise) begin
						dr = DIR_RIGHT;
						t  = enter(t, S_DELAY, now);
					end else if (item.right_barrier_rise) begin
						dr = DIR_LEFT;
						t  = enter(t, S_DELAY, now);
					end
				end
				if (button && !flt) begin
					t = enter(t, S_STOPPED, now);
				end
			end
			S_DELAY: begin
				if (elapsed(now, t.ent, {4'd0, cfg.start_delay_ms})) begin
					t = issue(t, CMD_SPEED);
					t = enter(t, S_RUN, now);
				end
			end
			S_RUN: begin
				t = issue(t, CMD_SPEED);
				if (elapsed(now, t.ent, cfg.transport_timeout_ms)) begin
					flt = 1'b1;
					t   = enter(t, S_FAULT, now);
				end
				if (md == MODE_LEFT) begin
					if (item.left_barrier_fall && !l_act) begin
						t = enter(t, S_BRAKING, now);
					end
				end else if (md == MODE_RIGHT) begin
					if (item.right_barrier_fall && !r_act) begin
						t = enter(t, S_BRAKING, now);
					end
				end else begin
					if (dr == DIR_LEFT && item.left_barrier_rise) begin
						t = enter(t, S_TARGET, now);
					end else if (dr == DIR_RIGHT && item.right_barrier_rise) begin
						t = enter(t, S_TARGET, now);
					end
				end
				if (button && !flt) begin
					t = enter(t, S_STOPPED, now);
				end
			end
			S_BRAKING: begin
				if (item.motor_standstill) begin
					t = enter(t, S_AWAIT, now);
				end
			end
			S_TARGET: begin
				if (item.motor_standstill &&
					elapsed(now, t.ent, {4'd0, cfg.target_wait_ms})) begin
					if (l_act || r_act) begin
						dr = (dr == DIR_LEFT) ? DIR_RIGHT : DIR_LEFT;
						t  = issue(t, CMD_SPEED);
						t  = enter(t, S_RUN, now);
					end else begin
						t = enter(t, S_AWAIT, now);
					end
				end
			end
			S_STOPPED: begin
				if (button) begin
					t = enter(t, S_AWAIT, now);
				end
			end
			S_FAULT: begin
				if (button) begin
					flt = 1'b0;
					t   = enter(t, S_AWAIT, now);
				end
			end
			S_MODECHG: begin
				if (item.motor_standstill && button) begin
					md = sw;
					t  = enter(t, S_MODESHOW, now);
				end
			end
			S_MODESHOW: begin
				if (elapsed(now, t.ent, {4'd0, cfg.mode_show_ms})) begin
					t = enter(t, S_AWAIT, now);
				end
			end
			default: t = enter(t, S_STARTUP, now);
		endcase

		res.seq_state     = t.st;
		res.motor_cmd     = t.cmd;
		res.drive_dir     = dr;
		res.speed_cmd     = (t.cmd == CMD_SPEED) ? item.target_speed : 16'd0;
		res.active_mode   = md;
		res.screen_event  = t.scr;
		res.fault_timeout = flt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_STARTUP;
			mode_q  <= MODE_AUTO;
			dir_q   <= DIR_STOP;
			entry_q <= '0;
			fault_q <= 1'b0;
		end else if (fire) begin
			state_q <= t.st;
			mode_q  <= md;
			dir_q   <= dr;
			entry_q <= t.ent;
			fault_q <= flt;
		end
	end
endmodule

/* sv/conveyor_transport_sequencer_core.sv */
// Top level of the conveyor transport sequencer: input register, tick logic and
// result register, plus the APB-style timing register bank.
// Depends on cts_pkg, cts_if, cts_cfg and cts_ctrl.
//
// Usage: one transaction on tick_in is one control tick (time, barrier levels
// and edges, button, rocker switch, standstill, speed setpoint). Every tick
// yields exactly one transaction on result_out with the motor command, screen
// event, sequencer state, direction, mode and timeout fault.
// An accepted tick is registered in the input register; its result is then
// registered in the result register, where it is valid. Throughput is one
// tick per cycle while result_out accepts; sequencer state updates in the same
// edge that loads the result register, so the next tick sees it immediately.
// When the receiver stalls, the result register holds its transaction and the
// input register keeps one more tick; tick_in.ready falls only when both are
// full. Reset clears both registers' valid flags and returns the sequencer to
// the startup screen with automatic mode, stopped direction, a zero entry time
// and no fault; timing registers return to defaults. Users must write configuration
// over the APB-style port only while no tick is in flight; not enforced here.
module conveyor_transport_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	cts_in_if.sink                         tick_in,
	cts_out_if.source                      result_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cts_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cts_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cts_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cts_pkg::*;

	cfg_t      cfg;
	in_item_t  item_in;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      advance;
	logic      accept;

	cts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign item_in.now_ms               = tick_in.now_ms;
	assign item_in.left_barrier_active  = tick_in.left_barrier_active;
	assign item_in.right_barrier_active = tick_in.right_barrier_active;
	assign item_in.left_barrier_rise    = tick_in.left_barrier_rise;
	assign item_in.left_barrier_fall    = tick_in.left_barrier_fall;
	assign item_in.right_barrier_rise   = tick_in.right_barrier_rise;
	assign item_in.right_barrier_fall   = tick_in.right_barrier_fall;
	assign item_in.button_rise          = tick_in.button_rise;
	assign item_in.switch_mode          = tick_in.switch_mode;
	assign item_in.switch_changed       = tick_in.switch_changed;
	assign item_in.motor_standstill     = tick_in.motor_standstill;
	assign item_in.target_speed         = tick_in.target_speed;

	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign tick_in.ready = !valid_s1 || advance;
	assign accept        = tick_in.valid && tick_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_out.valid         = valid_s2;
	assign result_out.seq_state     = res_s2.seq_state;
	assign result_out.motor_cmd     = res_s2.motor_cmd;
	assign result_out.drive_dir     = res_s2.drive_dir;
	assign result_out.speed_cmd     = res_s2.speed_cmd;
	assign result_out.active_mode   = res_s2.active_mode;
	assign result_out.screen_event  = res_s2.screen_event;
	assign result_out.fault_timeout = res_s2.fault_timeout;
endmodule
